// File: src/nzrle_pkg.sv
// ----------------------------------------------------------------------------
// nzrle_pkg
// Shared constants and control/status types for the nibble zero-run decoder.
// ----------------------------------------------------------------------------
package nzrle_pkg;

	// Copy span of a copy half: it passes COPY_SPAN - length literals
	localparam logic [3:0] COPY_SPAN = 4'd8;

	// Decoder phase codes
	localparam logic [1:0] PH_CTRL  = 2'd0;
	localparam logic [1:0] PH_COPY1 = 2'd1;
	localparam logic [1:0] PH_COPY2 = 2'd2;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;  // input item accepted: latch its results, advance decoder state
		logic pop;   // output item taken: advance to the next result
	} nzrle_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic plan_any;  // the offered input item causes at least one result
		logic last;      // the result on the output is the final one of its item
	} nzrle_stat_t;

endpackage

// File: src/nzrle_ifs.sv
// ----------------------------------------------------------------------------
// nzrle channel interfaces
// Valid/ready channels for compressed input items and decoded output items.
// ----------------------------------------------------------------------------
interface nzrle_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       block_end;

	modport source (output valid, output in_byte, output block_end, input ready);
	modport sink   (input valid, input in_byte, input block_end, output ready);
endinterface

interface nzrle_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;
	logic       block_done;

	modport source (output valid, output out_byte, output last_of_run,
		output block_done, input ready);
	modport sink   (input valid, input out_byte, input last_of_run,
		input block_done, output ready);
endinterface

// File: src/nzrle_ctrl.sv
// ----------------------------------------------------------------------------
// nzrle_ctrl
// Controller: takes one input item, then steps the datapath through its results.
// ----------------------------------------------------------------------------
module nzrle_ctrl
	import nzrle_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  nzrle_stat_t stat,
	output nzrle_cmd_t  cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic state_q;
	logic state_d;

	// Handshake outputs follow the state
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign cmd.load  = in_valid & in_ready;
	assign cmd.pop   = out_valid & out_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load && stat.plan_any) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (cmd.pop && stat.last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: src/nzrle_dp.sv
// ----------------------------------------------------------------------------
// nzrle_dp
// Datapath: decoder state, decode of one input item into an optional literal
// followed by a zero run, and the result counter that drives the output.
// ----------------------------------------------------------------------------
module nzrle_dp
	import nzrle_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  nzrle_cmd_t  cmd,
	input  logic [7:0]  in_byte,
	input  logic        block_end,
	output logic [7:0]  out_byte,
	output logic        last_of_run,
	output logic        block_done,
	output nzrle_stat_t stat
);

	// Decoder state
	logic [1:0] phase_q;
	logic [3:0] copy_left_q;
	logic [3:0] pending_q;

	// Results of the item in flight
	logic       lit_pend_q;
	logic [7:0] lit_q;
	logic [4:0] zcnt_q;
	logic       end_q;

	// Decode outputs
	logic [1:0] phase_d;
	logic [3:0] copy_left_d;
	logic [3:0] pending_d;
	logic       lit_d;
	logic [4:0] zcnt_d;
	logic [3:0] half2;
	logic [3:0] lo;
	logic [3:0] hi;

	assign lo = in_byte[3:0];
	assign hi = in_byte[7:4];

	// Decode the offered item against the current phase
	always_comb begin
		phase_d     = phase_q;
		copy_left_d = copy_left_q;
		pending_d   = pending_q;
		lit_d       = 1'b0;
		zcnt_d      = 5'd0;
		half2       = 4'd0;
		case (phase_q)
			PH_COPY1: begin
				lit_d = 1'b1;
				if (copy_left_q <= 4'd1 || block_end) begin
					copy_left_d = 4'd0;
					half2       = pending_q;
					phase_d     = PH_CTRL;
				end else begin
					copy_left_d = copy_left_q - 4'd1;
				end
			end
			PH_COPY2: begin
				lit_d = 1'b1;
				if (copy_left_q <= 4'd1 || block_end) begin
					copy_left_d = 4'd0;
					phase_d     = PH_CTRL;
				end else begin
					copy_left_d = copy_left_q - 4'd1;
				end
			end
			default: begin
				phase_d = PH_CTRL;
				if (lo[3]) begin
					zcnt_d = {2'b00, lo[2:0]} + 5'd1;
					half2  = hi;
				end else if (!block_end) begin
					phase_d     = PH_COPY1;
					copy_left_d = COPY_SPAN - {1'b0, lo[2:0]};
					pending_d   = hi;
				end else begin
					half2 = hi;
				end
			end
		endcase

		// Second half: its zeros follow, or its copy starts unless the block ends
		if (phase_d == PH_CTRL) begin
			if (half2[3]) begin
				zcnt_d = zcnt_d + {2'b00, half2[2:0]} + 5'd1;
			end else if (!block_end && (phase_q != PH_COPY2)) begin
				phase_d     = PH_COPY2;
				copy_left_d = COPY_SPAN - {1'b0, half2[2:0]};
			end
		end

		// Block end returns all decoder state to reset
		if (block_end) begin
			phase_d     = PH_CTRL;
			copy_left_d = 4'd0;
			pending_d   = 4'd0;
		end
	end

	assign stat.plan_any = lit_d | (zcnt_d != 5'd0);
	assign stat.last     = lit_pend_q ? (zcnt_q == 5'd0) : (zcnt_q == 5'd1);

	// Output payload: literal first, then the zero run
	assign out_byte    = lit_pend_q ? lit_q : 8'd0;
	assign last_of_run = stat.last;
	assign block_done  = stat.last & end_q;

	// Decoder state and result counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_CTRL;
			copy_left_q <= 4'd0;
			pending_q   <= 4'd0;
			lit_pend_q  <= 1'b0;
			zcnt_q      <= 5'd0;
		end else if (cmd.load) begin
			phase_q     <= phase_d;
			copy_left_q <= copy_left_d;
			pending_q   <= pending_d;
			lit_pend_q  <= lit_d;
			zcnt_q      <= zcnt_d;
		end else if (cmd.pop) begin
			if (lit_pend_q) begin
				lit_pend_q <= 1'b0;
			end else begin
				zcnt_q <= zcnt_q - 5'd1;
			end
		end
	end

	// Payload of the item in flight
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lit_q <= in_byte;
			end_q <= block_end;
		end
	end

endmodule

// File: src/nibble_zero_rle_decoder_unit.sv
// ----------------------------------------------------------------------------
// nibble_zero_rle_decoder_unit
// Zero run-length decoder with nibble-coded control bytes.
// ----------------------------------------------------------------------------
//  channel | role  | payload                                  | accepted when
//  comp    | sink  | in_byte[7:0], block_end                  | valid & ready
//  decomp  | source| out_byte[7:0], last_of_run, block_done    | valid & ready
//
//  An item that causes n results (0 to 16) is taken and decoded while the
//  unit is idle, then the result counter hands out its results in order.
//  The input is not ready while results of the previous item are pending.
//  A stall on the output holds the current result and the counter.
//  Reset clears the controller, the decoder phase and the result counter.
// ----------------------------------------------------------------------------
module nibble_zero_rle_decoder_unit
	import nzrle_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	nzrle_in_if.sink    comp,
	nzrle_out_if.source decomp
);

	nzrle_cmd_t  cmd;
	nzrle_stat_t stat;

	// Sequence items through the datapath
	nzrle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (comp.valid),
		.in_ready  (comp.ready),
		.out_valid (decomp.valid),
		.out_ready (decomp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Decode and hold results
	nzrle_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_byte     (comp.in_byte),
		.block_end   (comp.block_end),
		.out_byte    (decomp.out_byte),
		.last_of_run (decomp.last_of_run),
		.block_done  (decomp.block_done),
		.stat        (stat)
	);

endmodule

// File: tb/nzrle_decode_checker.sv
// ----------------------------------------------------------------------------
// nzrle_decode_checker
// Watches both channels of the nibble zero-run decoder. It decodes each
// accepted compressed item in its own model of the decoder and compares
// every accepted output item, field by field, with the oldest decoded byte
// still owed. It reports the failure count and the number of bytes still owed.
// ----------------------------------------------------------------------------
module nzrle_decode_checker
	import nzrle_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	nzrle_in_if         comp,
	nzrle_out_if        decomp,
	output int          errors,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       block_done;
	} decoded_t;

	// Decoder model state
	logic [1:0] dec_phase;
	logic [3:0] copy_left;
	logic [3:0] pending_half;

	decoded_t item_bytes[$];   // bytes caused by the item being decoded
	decoded_t owed_bytes[$];   // bytes decoded but not yet seen on the output

	initial begin
		errors      = 0;
		outstanding = 0;
	end

	function automatic void add_byte(input logic [7:0] b);
		decoded_t d;
		d = '{b, 1'b0, 1'b0};
		item_bytes.insert(item_bytes.size(), d);
	endfunction

	function automatic void add_zeros(input logic [3:0] half);
		for (int i = 0; i <= int'(half[2:0]); i++)
			add_byte(8'h00);
	endfunction

	// Finish the second half: zero fill now, or start its copy unless the block ends
	function automatic void run_second_half(input logic [3:0] half, input logic fin);
		if (half[3]) begin
			add_zeros(half);
			dec_phase = PH_CTRL;
		end else if (!fin) begin
			dec_phase = PH_COPY2;
			copy_left = COPY_SPAN - {1'b0, half[2:0]};
		end else begin
			dec_phase = PH_CTRL;
		end
	endfunction

	// Decode one compressed item and queue the bytes it causes
	function automatic void decode_item(input logic [7:0] b, input logic fin);
		logic [3:0] lo;
		logic [3:0] hi;
		lo = b[3:0];
		hi = b[7:4];
		item_bytes.delete();
		case (dec_phase)
			PH_COPY1: begin
				add_byte(b);
				if (copy_left <= 4'd1 || fin) begin
					copy_left = 4'd0;
					run_second_half(pending_half, fin);
				end else begin
					copy_left = copy_left - 4'd1;
				end
			end
			PH_COPY2: begin
				add_byte(b);
				if (copy_left <= 4'd1 || fin) begin
					copy_left = 4'd0;
					dec_phase = PH_CTRL;
				end else begin
					copy_left = copy_left - 4'd1;
				end
			end
			default: begin
				// control byte; the unused phase code lands here too
				dec_phase = PH_CTRL;
				if (lo[3]) begin
					add_zeros(lo);
					run_second_half(hi, fin);
				end else if (!fin) begin
					dec_phase    = PH_COPY1;
					copy_left    = COPY_SPAN - {1'b0, lo[2:0]};
					pending_half = hi;
				end else begin
					run_second_half(hi, fin);
				end
			end
		endcase
		if (fin) begin
			dec_phase    = PH_CTRL;
			copy_left    = 4'd0;
			pending_half = 4'd0;
		end
		if (item_bytes.size() > 0) begin
			item_bytes[item_bytes.size()-1].last_of_run = 1'b1;
			item_bytes[item_bytes.size()-1].block_done  = fin;
		end
		foreach (item_bytes[i])
			owed_bytes.insert(owed_bytes.size(), item_bytes[i]);
	endfunction

	// Predict on accepted input items, compare accepted output items
	always @(posedge clk or negedge arst_n) begin
		decoded_t want;
		if (!arst_n) begin
			dec_phase    = PH_CTRL;
			copy_left    = 4'd0;
			pending_half = 4'd0;
			owed_bytes.delete();
		end else begin
			if (comp.valid && comp.ready)
				decode_item(comp.in_byte, comp.block_end);
			if (decomp.valid && decomp.ready) begin
				if (owed_bytes.size() == 0) begin
					$error("unexpected output item: out_byte %h last_of_run %b block_done %b",
						decomp.out_byte, decomp.last_of_run, decomp.block_done);
					errors = errors + 1;
				end else begin
					want = owed_bytes.pop_front();
					if (decomp.out_byte !== want.out_byte) begin
						$error("out_byte: expected %h, got %h", want.out_byte, decomp.out_byte);
						errors = errors + 1;
					end
					if (decomp.last_of_run !== want.last_of_run) begin
						$error("last_of_run: expected %b, got %b",
							want.last_of_run, decomp.last_of_run);
						errors = errors + 1;
					end
					if (decomp.block_done !== want.block_done) begin
						$error("block_done: expected %b, got %b",
							want.block_done, decomp.block_done);
						errors = errors + 1;
					end
				end
			end
		end
		outstanding = owed_bytes.size();
	end

endmodule

// File: tb/tb_nibble_zero_rle_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_nibble_zero_rle_decoder_unit
// Drives compressed items into the nibble zero-run decoder: a directed set
// covering the zero and copy halves, block ends in every phase and items
// with no output, then random streams under several idle and stall mixes,
// including one long output hold-off. The checker does the comparing.
// ----------------------------------------------------------------------------
module tb_nibble_zero_rle_decoder_unit;
	import nzrle_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 300000;
	localparam int LONG_HOLD   = 300;

	logic clk;
	logic arst_n;
	int   errors;
	int   outstanding;
	int   send_idle_pct;
	int   recv_stall_pct;
	bit   long_hold_req;

	nzrle_in_if  comp_if ();
	nzrle_out_if decomp_if ();

	nibble_zero_rle_decoder_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.comp   (comp_if),
		.decomp (decomp_if)
	);

	nzrle_decode_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.comp        (comp_if),
		.decomp      (decomp_if),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Abort a hung run
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

	// Output side: random stalls, plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left       = 0;
		decomp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				hold_left     = LONG_HOLD;
				long_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				decomp_if.ready <= 1'b0;
				hold_left = hold_left - 1;
			end else begin
				decomp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Offer one compressed item, idling first at random, and hold until taken
	task automatic send_item(input logic [7:0] b, input logic fin);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			comp_if.valid <= 1'b0;
			@(posedge clk);
		end
		comp_if.valid     <= 1'b1;
		comp_if.in_byte   <= b;
		comp_if.block_end <= fin;
		do @(posedge clk); while (!comp_if.ready);
	endtask

	// Random stream; bias a share of bytes to the longest and shortest halves
	task automatic send_random(input int count);
		logic [7:0] b;
		for (int i = 0; i < count; i++) begin
			b = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 4) == 0)
				b = {b[7], 3'b111, b[3], 3'b000};
			send_item(b, $urandom_range(0, 9) == 0);
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		send_idle_pct     = 0;
		recv_stall_pct    = 0;
		long_hold_req     = 1'b0;
		comp_if.valid     = 1'b0;
		comp_if.in_byte   = 8'h00;
		comp_if.block_end = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// two full zero runs, then two single zeros
		send_item(8'hFF, 1'b0);
		send_item(8'h88, 1'b0);
		// single zero, then a full copy of eight literals
		send_item(8'h08, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'hA5, 1'b0);
		send_item(8'h5A, 1'b0);
		send_item(8'h01, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(8'h7E, 1'b0);
		send_item(8'h3C, 1'b0);
		// two one-literal copies: the control byte itself yields nothing
		send_item(8'h77, 1'b0);
		send_item(8'hC3, 1'b0);
		send_item(8'h3C, 1'b0);
		// block end on a control byte: first copy skipped, second zeros kept
		send_item(8'h87, 1'b1);
		// block end on a control byte with two copy halves: nothing at all
		send_item(8'h07, 1'b1);
		// block end cuts a first-half copy; second-half zeros still follow
		send_item(8'hF0, 1'b0);
		send_item(8'hAA, 1'b1);
		// block end cuts a second-half copy
		send_item(8'h08, 1'b0);
		send_item(8'h55, 1'b0);
		send_item(8'h66, 1'b1);
		// largest expansion, closing a block
		send_item(8'hFF, 1'b1);

		// no idling, with one long output hold-off at the start
		long_hold_req = 1'b1;
		send_random(40);
		// sender mostly idle
		send_idle_pct = 74;
		send_random(35);
		// receiver mostly stalling
		send_idle_pct  = 0;
		recv_stall_pct = 74;
		send_random(35);
		// both sides idle now and then
		send_idle_pct  = 30;
		recv_stall_pct = 30;
		send_random(40);

		comp_if.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: files.f
src/nzrle_pkg.sv
src/nzrle_ifs.sv
src/nzrle_ctrl.sv
src/nzrle_dp.sv
src/nibble_zero_rle_decoder_unit.sv
tb/nzrle_decode_checker.sv
tb/tb_nibble_zero_rle_decoder_unit.sv
